>>> sv/ipg_pkg.sv
package ipg_pkg;

   // Field widths
   localparam int CNT_W = 16;
   localparam int CH_W  = 8;
   localparam int CH_N  = 3;

   // Channel slots inside an rgb_type
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Palette geometry
   localparam int PAL_SIZE = 24;
   localparam int IDX_W    = $clog2(PAL_SIZE);
   localparam logic [IDX_W-1:0] PAL_LAST = IDX_W'(PAL_SIZE - 1);

   // n = count * (PAL_SIZE-1) and its quotient by the limit (below PAL_SIZE)
   localparam int Q_BITS = IDX_W;
   localparam int N_W    = CNT_W + IDX_W;

   // Interpolation numerator a*mx + (b-a)*r stays below 2^CH_W * mx
   localparam int NUM_W  = CH_W + CNT_W;
   localparam int PROD_W = NUM_W + 2;
   localparam int CD_BITS = CH_W;

   // Pipeline stage map
   localparam int ST_LOOKUP = Q_BITS + 1;
   localparam int ST_SUM    = ST_LOOKUP + 1;
   localparam int NS        = ST_SUM + 1 + CD_BITS;

   localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(256);

   typedef logic [CH_N-1:0][CH_W-1:0]  rgb_type;
   typedef logic [CH_N-1:0][NUM_W-1:0] num_vec_type;

   function automatic rgb_type mk_rgb(input logic [CH_W-1:0] r,
                                      input logic [CH_W-1:0] g,
                                      input logic [CH_W-1:0] b);
      rgb_type c;
      c[CH_RED]   = r;
      c[CH_GREEN] = g;
      c[CH_BLUE]  = b;
      return c;
   endfunction

   // Palette ROM; indices past the end read as the last entry (black)
   function automatic rgb_type pal_color(input logic [IDX_W-1:0] idx);
      rgb_type c;
      case (idx)
         5'd0:    c = mk_rgb(8'd8,   8'd10,  8'd25);
         5'd1:    c = mk_rgb(8'd15,  8'd20,  8'd45);
         5'd2:    c = mk_rgb(8'd25,  8'd35,  8'd70);
         5'd3:    c = mk_rgb(8'd35,  8'd55,  8'd100);
         5'd4:    c = mk_rgb(8'd50,  8'd80,  8'd130);
         5'd5:    c = mk_rgb(8'd70,  8'd105, 8'd160);
         5'd6:    c = mk_rgb(8'd95,  8'd130, 8'd185);
         5'd7:    c = mk_rgb(8'd120, 8'd155, 8'd205);
         5'd8:    c = mk_rgb(8'd145, 8'd180, 8'd220);
         5'd9:    c = mk_rgb(8'd170, 8'd200, 8'd230);
         5'd10:   c = mk_rgb(8'd190, 8'd215, 8'd235);
         5'd11:   c = mk_rgb(8'd210, 8'd225, 8'd230);
         5'd12:   c = mk_rgb(8'd235, 8'd210, 8'd180);
         5'd13:   c = mk_rgb(8'd245, 8'd180, 8'd130);
         5'd14:   c = mk_rgb(8'd250, 8'd145, 8'd90);
         5'd15:   c = mk_rgb(8'd250, 8'd110, 8'd60);
         5'd16:   c = mk_rgb(8'd245, 8'd80,  8'd45);
         5'd17:   c = mk_rgb(8'd235, 8'd55,  8'd40);
         5'd18:   c = mk_rgb(8'd210, 8'd40,  8'd40);
         5'd19:   c = mk_rgb(8'd170, 8'd30,  8'd45);
         5'd20:   c = mk_rgb(8'd120, 8'd22,  8'd42);
         5'd21:   c = mk_rgb(8'd70,  8'd15,  8'd35);
         5'd22:   c = mk_rgb(8'd30,  8'd8,   8'd25);
         default: c = mk_rgb(8'd0,   8'd0,   8'd0);
      endcase
      return c;
   endfunction

endpackage

>>> sv/iteration_palette_gradient_top.sv
// Escape-time palette gradient: one iteration count in, one RGB color out.
// req_* carries iteration_count; rsp_* returns red, green and blue. Both
// channels use valid/ready and a transaction moves when both are high.
// csr_wr_en/csr_wr_data set the iteration limit (reset value 256); write it
// only while no transaction is in flight.
// Counts at or above the limit give black. Others are split by a five-stage
// restoring divider into palette index and remainder, the two neighboring
// entries are blended with two multipliers per channel, and each channel goes
// through an eight-stage divider by the limit.
// The pipeline has 16 register stages and takes one transaction per cycle
// while rsp_ready does not stall it.
// Every stage has a valid bit and holds only when the stage after it is
// full and held, so an rsp_ready low stalls the tail while bubbles ahead of
// it still fill; req_ready drops only when all stages are occupied.
// Synchronous reset empties the pipeline and restores the limit; no
// clearing pass is needed.
module iteration_palette_gradient_top import ipg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CNT_W-1:0] req_iteration_count,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CH_W-1:0]  rsp_red,
   output logic [CH_W-1:0]  rsp_green,
   output logic [CH_W-1:0]  rsp_blue,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   logic [CNT_W-1:0] max_iter_ff;

   logic [NS-1:0]    vld_ff;
   logic [NS-1:0]    vld_in;
   logic [NS-1:0]    stage_en;
   logic             interior_ff [0:NS-1];
   logic [CNT_W-1:0] mx_ff       [0:ST_SUM];

   logic [N_W-1:0]   qrem_ff [0:Q_BITS];
   logic [IDX_W-1:0] qquo_ff [0:Q_BITS];

   logic [CH_N-1:0][NUM_W-1:0]          pa_ff;
   logic signed [CH_N-1:0][PROD_W-1:0]  pd_ff;
   logic [CH_N-1:0][NUM_W-1:0]          pa_in;
   logic signed [CH_N-1:0][PROD_W-1:0]  pd_in;
   logic signed [CH_N-1:0][PROD_W-1:0]  sum_in;
   num_vec_type                         num_ff;
   num_vec_type                         num_in;
   rgb_type                             div_color;
   rgb_type                             rsp_color;

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_wr_en) begin
         max_iter_ff <= csr_wr_data;
      end
   end

   // Stage enables: a stage loads when it is empty or its successor moves
   always_comb begin
      stage_en[NS-1] = !vld_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (stage_en[k]) begin
            vld_in[k] = (k == 0) ? req_valid : vld_ff[(k == 0) ? 0 : k - 1];
         end else begin
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stage_en[0];

   // Interior flag follows the item down the whole pipeline
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         interior_ff[0] <= (req_iteration_count >= max_iter_ff);
      end
      for (int k = 1; k < NS; k++) begin
         if (stage_en[k]) begin
            interior_ff[k] <= interior_ff[k-1];
         end
      end
   end

   // Limit travels with the item as far as the channel divider
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         mx_ff[0] <= max_iter_ff;
      end
      for (int k = 1; k <= ST_SUM; k++) begin
         if (stage_en[k]) begin
            mx_ff[k] <= mx_ff[k-1];
         end
      end
   end

   // Stage 0: n = count * (PAL_SIZE - 1)
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         qrem_ff[0] <= N_W'(req_iteration_count) * N_W'(PAL_LAST);
         qquo_ff[0] <= '0;
      end
   end

   // Stages 1..Q_BITS: palette index and remainder, one bit per stage
   for (genvar k = 1; k <= Q_BITS; k++) begin : g_qstep
      localparam int BIT = Q_BITS - k;

      logic [N_W:0]     trial;
      logic [N_W-1:0]   qrem_in;
      logic [IDX_W-1:0] qquo_in;

      always_comb begin
         trial   = {1'b0, qrem_ff[k-1]} - ((N_W + 1)'(mx_ff[k-1]) << BIT);
         qrem_in = qrem_ff[k-1];
         qquo_in = qquo_ff[k-1];
         if (!trial[N_W]) begin
            qrem_in      = trial[N_W-1:0];
            qquo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            qrem_ff[k] <= qrem_in;
            qquo_ff[k] <= qquo_in;
         end
      end
   end

   // Lookup stage: neighboring entries and the two products per channel
   always_comb begin
      logic [IDX_W:0]           idx_inc;
      logic [IDX_W-1:0]         idx_j;
      rgb_type                  col_a;
      rgb_type                  col_b;
      logic signed [CH_W:0]     delta;
      logic signed [CNT_W:0]    rem_s;
      idx_inc = {1'b0, qquo_ff[Q_BITS]} + (IDX_W + 1)'(1);
      idx_j   = (idx_inc < (IDX_W + 1)'(PAL_LAST)) ? idx_inc[IDX_W-1:0] : PAL_LAST;
      col_a   = pal_color(qquo_ff[Q_BITS]);
      col_b   = pal_color(idx_j);
      rem_s   = $signed({1'b0, qrem_ff[Q_BITS][CNT_W-1:0]});
      for (int ch = 0; ch < CH_N; ch++) begin
         delta     = $signed({1'b0, col_b[ch]}) - $signed({1'b0, col_a[ch]});
         pa_in[ch] = NUM_W'(col_a[ch]) * NUM_W'(mx_ff[Q_BITS]);
         pd_in[ch] = PROD_W'(delta) * PROD_W'(rem_s);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_LOOKUP]) begin
         pa_ff <= pa_in;
         pd_ff <= pd_in;
      end
   end

   // Sum stage: numerator a*mx + (b-a)*r, never negative
   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) begin
         sum_in[ch] = $signed({2'b00, pa_ff[ch]}) + pd_ff[ch];
         num_in[ch] = sum_in[ch][NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         num_ff <= num_in;
      end
   end

   // Channel dividers: floor(numerator / mx)
   ipg_chan_div u_chan_div (
      .clock     (clock),
      .stage_en  (stage_en[NS-1:ST_SUM+1]),
      .num_in    (num_ff),
      .mx_in     (mx_ff[ST_SUM]),
      .color_out (div_color)
   );

   // Output: interior counts show the last palette entry
   assign rsp_color = interior_ff[NS-1] ? pal_color(PAL_LAST) : div_color;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_red   = rsp_color[CH_RED];
   assign rsp_green = rsp_color[CH_GREEN];
   assign rsp_blue  = rsp_color[CH_BLUE];

`ifndef SYNTHESIS
   // Index division leaves a valid palette index and a remainder below the limit
   a_qdiv_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[Q_BITS] && !interior_ff[Q_BITS] |->
         (qquo_ff[Q_BITS] < PAL_LAST) && (qrem_ff[Q_BITS] < N_W'(mx_ff[Q_BITS])))
      else $error("palette index division out of range");

   // Blend numerator is non-negative and fits the channel divider
   a_num_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_LOOKUP] && !interior_ff[ST_LOOKUP] |->
         (sum_in[CH_RED][PROD_W-1:NUM_W] == '0) &&
         (sum_in[CH_GREEN][PROD_W-1:NUM_W] == '0) &&
         (sum_in[CH_BLUE][PROD_W-1:NUM_W] == '0))
      else $error("blend numerator out of range");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

>>> sv/ipg_chan_div.sv
// Pipelined restoring divider for the three color channels: one quotient
// bit per stage, numerator below 2^CD_BITS times the divisor.
module ipg_chan_div import ipg_pkg::*; (
   input  logic                clock,
   input  logic [CD_BITS-1:0]  stage_en,
   input  num_vec_type         num_in,
   input  logic [CNT_W-1:0]    mx_in,
   output rgb_type             color_out
);

   num_vec_type      rem_ff [0:CD_BITS-2];
   logic [CNT_W-1:0] mx_ff  [0:CD_BITS-2];
   rgb_type          quo_ff [0:CD_BITS-1];

   for (genvar s = 0; s < CD_BITS; s++) begin : g_step
      localparam int BIT = CD_BITS - 1 - s;

      num_vec_type      rem_src;
      rgb_type          quo_src;
      logic [CNT_W-1:0] mx_src;
      num_vec_type      rem_in;
      rgb_type          quo_in;

      if (s == 0) begin : g_first
         assign rem_src = num_in;
         assign quo_src = '0;
         assign mx_src  = mx_in;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign mx_src  = mx_ff[s-1];
      end

      // Trial subtract of the shifted divisor, per channel
      always_comb begin
         logic [NUM_W:0] trial;
         quo_in = quo_src;
         rem_in = rem_src;
         for (int ch = 0; ch < CH_N; ch++) begin
            trial = {1'b0, rem_src[ch]} - ((NUM_W + 1)'(mx_src) << BIT);
            if (!trial[NUM_W]) begin
               rem_in[ch]      = trial[NUM_W-1:0];
               quo_in[ch][BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            quo_ff[s] <= quo_in;
         end
      end

      if (s < CD_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[s]) begin
               rem_ff[s] <= rem_in;
               mx_ff[s]  <= mx_src;
            end
         end
      end
   end

   assign color_out = quo_ff[CD_BITS-1];

endmodule

>>> tb/sv/iteration_palette_gradient_top_tb.sv
`timescale 1ns / 100ps

module iteration_palette_gradient_top_tb import ipg_pkg::*; ();

   localparam logic [CNT_W-1:0] RESET_LIMIT = 16'd256;
   localparam int PIPE_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENTS    = 23;

   // Palette entries as {red, green, blue}, entry 0 leftmost
   localparam logic [0:23][23:0] SHADES = {
      {8'd8,   8'd10,  8'd25},  {8'd15,  8'd20,  8'd45},  {8'd25,  8'd35,  8'd70},
      {8'd35,  8'd55,  8'd100}, {8'd50,  8'd80,  8'd130}, {8'd70,  8'd105, 8'd160},
      {8'd95,  8'd130, 8'd185}, {8'd120, 8'd155, 8'd205}, {8'd145, 8'd180, 8'd220},
      {8'd170, 8'd200, 8'd230}, {8'd190, 8'd215, 8'd235}, {8'd210, 8'd225, 8'd230},
      {8'd235, 8'd210, 8'd180}, {8'd245, 8'd180, 8'd130}, {8'd250, 8'd145, 8'd90},
      {8'd250, 8'd110, 8'd60},  {8'd245, 8'd80,  8'd45},  {8'd235, 8'd55,  8'd40},
      {8'd210, 8'd40,  8'd40},  {8'd170, 8'd30,  8'd45},  {8'd120, 8'd22,  8'd42},
      {8'd70,  8'd15,  8'd35},  {8'd30,  8'd8,   8'd25},  {8'd0,   8'd0,   8'd0}
   };

   typedef struct {
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] limit;
      rgb_type          color;
   } color_entry_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [CNT_W-1:0] req_iteration_count = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [CH_W-1:0]  rsp_red;
   logic [CH_W-1:0]  rsp_green;
   logic [CH_W-1:0]  rsp_blue;
   logic             csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   logic [CNT_W-1:0] pending_counts [$];
   color_entry_type  awaiting_colors [$];
   logic [CNT_W-1:0] active_limit = RESET_LIMIT;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               send_gap = 0;
   int               recv_gap = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;

   iteration_palette_gradient_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_iteration_count (req_iteration_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_red             (rsp_red),
      .rsp_green           (rsp_green),
      .rsp_blue            (rsp_blue),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Expected color: blend of two neighboring palette entries, exact integer math
   function automatic rgb_type shade_blend(input logic [CNT_W-1:0] count,
                                           input logic [CNT_W-1:0] lim);
      rgb_type  c;
      longint   scaled, seg, frac, lo, hi, num;
      int       hi_idx;
      if (count >= lim) begin
         c[CH_RED]   = SHADES[SEGMENTS][23:16];
         c[CH_GREEN] = SHADES[SEGMENTS][15:8];
         c[CH_BLUE]  = SHADES[SEGMENTS][7:0];
         return c;
      end
      scaled = longint'(count) * SEGMENTS;
      seg    = scaled / lim;
      frac   = scaled % lim;
      hi_idx = (seg + 1 < SEGMENTS) ? int'(seg + 1) : SEGMENTS;
      for (int ch = 0; ch < CH_N; ch++) begin
         lo  = SHADES[int'(seg)][23 - 8*ch -: 8];
         hi  = SHADES[hi_idx][23 - 8*ch -: 8];
         num = lo * lim + (hi - lo) * frac;
         c[ch] = CH_W'(num / lim);
      end
      return c;
   endfunction

   // Mostly counts below the limit, some at its edge, some anywhere
   function automatic logic [CNT_W-1:0] pick_count(input logic [CNT_W-1:0] lim);
      int roll;
      roll = $urandom_range(0, 99);
      if (lim != 0 && roll < 70)
         return CNT_W'($urandom_range(0, lim - 1));
      if (roll < 82)
         return lim + CNT_W'($urandom_range(0, 2)) - 1'b1;
      return CNT_W'($urandom);
   endfunction

   // Driver: one transaction per accepted count, prediction taken at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            awaiting_colors.push_back('{req_iteration_count, active_limit,
                                        shade_blend(req_iteration_count, active_limit)});
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else if (pending_counts.size() != 0) begin
               req_valid <= 1'b1;
               req_iteration_count <= pending_counts.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      color_entry_type exp_entry;
      rgb_type         got;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaiting_colors.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result %0d/%0d/%0d", $time,
                        rsp_red, rsp_green, rsp_blue);
            end else begin
               exp_entry = awaiting_colors.pop_front();
               got[CH_RED]   = rsp_red;
               got[CH_GREEN] = rsp_green;
               got[CH_BLUE]  = rsp_blue;
               for (int ch = 0; ch < CH_N; ch++) begin
                  if (got[ch] !== exp_entry.color[ch]) begin
                     mismatch_count++;
                     $display("%0t: count %0d limit %0d %s expected %0d actual %0d",
                              $time, exp_entry.count, exp_entry.limit,
                              ch == CH_RED ? "red" : (ch == CH_GREEN ? "green" : "blue"),
                              exp_entry.color[ch], got[ch]);
                  end
               end
            end
         end
         // stall bursts
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            recv_gap = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Hold off until every transaction has drained, then let the pipe settle
   task automatic wait_drained();
      while (pending_counts.size() != 0 || req_valid || awaiting_colors.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // New limit and idling mix, written only while the block is empty
   task automatic set_limit(input logic [CNT_W-1:0] lim, input int s_pct, input int r_pct);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= lim;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      active_limit = lim;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
   endtask

   initial begin
      logic [CNT_W-1:0] lim;
      int               s_pct, r_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset limit: first entry, blend into black just below the limit, saturation
      send_idle_pct = 20;
      recv_idle_pct = 20;
      pending_counts = '{16'd0, 16'd1, 16'd127, 16'd255, 16'd256, 16'hFFFF};
      // Zero limit: everything is interior
      set_limit(16'd0, 20, 20);
      pending_counts = '{16'd0, 16'd1, 16'hFFFF};
      // Smallest nonzero limit
      set_limit(16'd1, 0, 30);
      pending_counts = '{16'd0, 16'd1, 16'd2};
      // Limit equal to segment count: exact palette entries, no remainder
      set_limit(16'd23, 30, 0);
      pending_counts = '{16'd0, 16'd11, 16'd22, 16'd23};
      // Largest limit
      set_limit(16'hFFFF, 10, 10);
      pending_counts = '{16'd0, 16'd32768, 16'd65534, 16'hFFFF};

      // Random phases; the last one runs without idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       lim = 16'hFFFF;
            1:       lim = CNT_W'($urandom_range(2, 64));
            2:       lim = CNT_W'($urandom_range(65, 4095));
            3:       lim = CNT_W'($urandom);
            4:       lim = 16'd1;
            5:       lim = 16'd24;
            6:       lim = 16'd0;
            default: lim = RESET_LIMIT;
         endcase
         s_pct = (ph == 7) ? 0 : $urandom_range(0, 3) * 12;
         r_pct = (ph == 7) ? 0 : $urandom_range(0, 3) * 12;
         set_limit(lim, s_pct, r_pct);
         for (int k = 0; k < ((ph == 6) ? 30 : 88); k++)
            pending_counts.push_back(pick_count(lim));
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
sv/ipg_pkg.sv
sv/ipg_chan_div.sv
sv/iteration_palette_gradient_top.sv
tb/sv/iteration_palette_gradient_top_tb.sv
